@@ rtl/core/sosc_pkg.sv @@
// sosc_pkg: shared types, constants and tables for the sine oscillator
// holds the cordic arctangent table, lane struct and register indexes
// no dependencies
package sosc_pkg;

	// default parameter values
	localparam int PHASE_BITS_DEF    = 32;
	localparam int CORDIC_STAGES_DEF = 18;

	// configuration register indexes
	localparam int               CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 2'd1;

	// field widths
	localparam int FREQ_W  = 24;
	localparam int AMP_W   = 16;
	localparam int OFF_W   = 24;
	localparam int OUT_W   = 24;
	localparam int RATE_W  = 19;
	localparam int CFG_W   = 32;
	localparam int STEP_W  = 32;
	localparam int INCP_W  = FREQ_W + STEP_W;

	// step divider: 2^40 / frame_rate, one quotient bit per cycle
	localparam int DIV_BITS = 41;
	localparam int DIV_CNT_W = 6;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((64'd1 << 40) / 64'd44100);

	// cordic datapath widths
	localparam int XW = 34;
	localparam int ZW = 34;
	localparam int PW = XW + AMP_W;
	localparam int RND_W = PW - 23;
	localparam int SUM_W = RND_W + 1;
	localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);

	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	// arctangent of 2^-i in 32-bit turns
	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// one rotation lane travelling down the cordic chain
	typedef struct packed {
		logic                    vld;
		logic                    neg;
		logic signed [AMP_W-1:0] amp;
		logic signed [OFF_W-1:0] off;
		logic signed [XW-1:0]    x;
		logic signed [XW-1:0]    y;
		logic signed [ZW-1:0]    z;
	} sosc_lane_t;

endpackage

@@ rtl/core/sosc_step_div.sv @@
// sosc_step_div: restoring divider giving the phase step per hertz
// step = floor(2^40 / frame_rate), saturated to 32 bits; uses sosc_pkg
module sosc_step_div import sosc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [RATE_W-1:0] rate,
	output logic              busy,
	output logic [STEP_W-1:0] step
);

	logic [RATE_W-1:0]    div_q;
	logic [RATE_W-1:0]    rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;

	logic                 num_bit;
	logic [RATE_W:0]      rem_sh;
	logic                 take;
	logic [RATE_W:0]      rem_sub;
	logic [DIV_BITS-1:0]  quo_nxt;

	// only the top dividend bit is set
	assign num_bit = (cnt_q == DIV_CNT_W'(DIV_BITS));
	assign rem_sh  = {rem_q, num_bit};
	assign take    = (rem_sh >= {1'b0, div_q});
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign quo_nxt = {quo_q[DIV_BITS-2:0], take};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			step_q <= STEP_RESET;
		end else if (wr) begin
			if (rate == '0) begin
				busy_q <= 1'b0;
				step_q <= '1;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_BITS);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				step_q <= (|quo_nxt[DIV_BITS-1:STEP_W]) ? '1 : quo_nxt[STEP_W-1:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (wr) begin
			div_q <= rate;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
			quo_q <= quo_nxt;
		end
	end

	assign busy = busy_q;
	assign step = step_q;

endmodule

@@ rtl/core/sosc_cordic_cell.sv @@
// sosc_cordic_cell: one rotation-mode cordic iteration with its register
// shift and arctangent fixed by IDX; uses sosc_pkg
module sosc_cordic_cell import sosc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  sosc_lane_t lane_in,
	output sosc_lane_t lane_out
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TURNS[IDX]);

	sosc_lane_t lane_nxt;
	sosc_lane_t lane_q;
	logic signed [XW-1:0] x_sh;
	logic signed [XW-1:0] y_sh;

	assign x_sh = lane_in.x >>> IDX;
	assign y_sh = lane_in.y >>> IDX;

	// rotate towards zero residual angle
	always_comb begin
		lane_nxt = lane_in;
		if (!lane_in.z[ZW-1]) begin
			lane_nxt.x = lane_in.x - y_sh;
			lane_nxt.y = lane_in.y + x_sh;
			lane_nxt.z = lane_in.z - ATAN;
		end else begin
			lane_nxt.x = lane_in.x + y_sh;
			lane_nxt.y = lane_in.y - x_sh;
			lane_nxt.z = lane_in.z + ATAN;
		end
	end

	// hand on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else if (en) begin
			lane_q <= lane_nxt;
		end
	end

	assign lane_out = lane_q;

endmodule

@@ rtl/core/scaled_offset_sine_oscillator.sv @@
// scaled_offset_sine_oscillator: phase accumulator, cordic chain, scale and offset
// one item per cycle unless in_stall is raised
// a frame_rate write runs the step divider, input is held off while it is busy
// reset: frame_rate 44100 (step preset), phase 0, pipeline empty
// depends on sosc_pkg, sosc_step_div, sosc_cordic_cell
module scaled_offset_sine_oscillator import sosc_pkg::*; #(
	parameter int PHASE_BITS    = PHASE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FREQ_W-1:0]        frequency,
	input  logic signed [AMP_W-1:0]  amplitude,
	input  logic signed [OFF_W-1:0]  dc_offset,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  sample_out,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int NST = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int SH  = 48 - PHASE_BITS;

	logic en;
	logic acc;
	logic div_busy;
	logic [STEP_W-1:0] step;
	logic rate_wr;
	logic phase_wr;

	// global advance unless the result register is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en || div_busy;
	assign acc      = in_valid && !in_stall;
	assign rate_wr  = cfg_we && (cfg_index == REG_FRAME_RATE);
	assign phase_wr = cfg_we && (cfg_index == REG_START_PHASE);

	sosc_step_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rate_wr),
		.rate   (cfg_data[RATE_W-1:0]),
		.busy   (div_busy),
		.step   (step)
	);

	// stage 1: phase increment product
	logic                    vld_s1;
	logic [INCP_W-1:0]       incp_s1;
	logic signed [AMP_W-1:0] amp_s1;
	logic signed [OFF_W-1:0] off_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			incp_s1 <= INCP_W'(frequency) * INCP_W'(step);
			amp_s1  <= amplitude;
			off_s1  <= dc_offset;
		end
	end

	// phase accumulator, wraps modulo a full turn
	logic [PHASE_BITS-1:0] phase_q;
	logic [INCP_W-1:0]     inc_full;
	logic [PHASE_BITS-1:0] inc;
	logic [63:0]           init_w;
	logic [63:0]           turn_w;
	logic [31:0]           turn;
	logic                  fold;
	logic [31:0]           turn_f;

	assign inc_full = incp_s1 >> SH;
	assign inc      = inc_full[PHASE_BITS-1:0];
	assign init_w   = (64'(cfg_data) << 16) >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (phase_wr) begin
			phase_q <= init_w[PHASE_BITS-1:0];
		end else if (en && vld_s1) begin
			phase_q <= phase_q + inc;
		end
	end

	// left half-plane angles turned by half a turn
	assign turn_w = 64'(phase_q) << SH;
	assign turn   = turn_w[47:16];
	assign fold   = turn[31] ^ turn[30];
	assign turn_f = {turn[31] ^ fold, turn[30:0]};

	// stage 2: cordic start vector
	sosc_lane_t lane [NST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane[0] <= '0;
		end else if (en) begin
			lane[0].vld <= vld_s1;
			lane[0].neg <= fold;
			lane[0].amp <= amp_s1;
			lane[0].off <= off_s1;
			lane[0].x   <= CORDIC_X0;
			lane[0].y   <= '0;
			lane[0].z   <= {{(ZW-32){turn_f[31]}}, turn_f};
		end
	end

	// chain of rotation cells
	for (genvar i = 0; i < NST; i++) begin : g_cordic
		sosc_cordic_cell #(.IDX(i)) u_rot (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.lane_in  (lane[i]),
			.lane_out (lane[i+1])
		);
	end

	// stage 3: scale by amplitude
	logic                    vld_s3;
	logic signed [PW-1:0]    prod_s3;
	logic signed [OFF_W-1:0] off_s3;
	logic signed [XW-1:0]    sine;

	assign sine = lane[NST].neg ? -lane[NST].y : lane[NST].y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= lane[NST].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PW'(sine) * PW'(lane[NST].amp);
			off_s3  <= lane[NST].off;
		end
	end

	// round half up, add offset, saturate
	logic signed [PW-1:0]    prod_rnd;
	logic signed [SUM_W-1:0] sum;
	logic signed [OUT_W-1:0] sat;

	assign prod_rnd = prod_s3 + PW'(1 << 22);
	assign sum      = SUM_W'(signed'(prod_rnd[PW-1:23])) + SUM_W'(off_s3);

	always_comb begin
		if (sum > SUM_W'(OUT_MAX)) begin
			sat = OUT_W'(OUT_MAX);
		end else if (sum < SUM_W'(OUT_MIN)) begin
			sat = OUT_W'(OUT_MIN);
		end else begin
			sat = sum[OUT_W-1:0];
		end
	end

	// result register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

endmodule
